// ----- sv/m3inv_pkg.sv -----
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared widths, cofactor index tables and stage payload types for the
// 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package m3inv_pkg;

	// element format
	localparam int DW     = 32;
	localparam int FB     = 16;
	localparam int NE     = 9;

	// internal widths: cofactor, determinant partial product, determinant
	localparam int CW     = 2 * DW + 1;
	localparam int DPW    = 2 * DW + 1;
	localparam int DET_W  = 3 * DW + 3;
	// scaled numerator magnitude and divider compare width
	localparam int NUM_W  = CW + 2 * FB;
	localparam int CMP_W  = DET_W + DW;

	// division pipeline: overflow stage, one stage per quotient bit, output
	localparam int DIV_NS = DW + 1;
	localparam int DIV_ST = DIV_NS + 1;
	localparam int LATENCY = 5 + DIV_ST;

	// adjugate entry k = a[PX]*a[PY] - a[NX]*a[NY] (row-major indices)
	localparam int PX [NE] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int PY [NE] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int NX [NE] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int NY [NE] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

	typedef struct packed {
		logic [NE-1:0][NUM_W-1:0] num;
		logic [DET_W-1:0]         den;
		logic [NE-1:0]            neg;
		logic                     sing;
	} div_in_t;

	typedef struct packed {
		logic [NE-1:0][DW-1:0] r;
		logic                  sing;
		logic                  sat;
	} inv_res_t;

endpackage

// ----- sv/m3inv_ifs.sv -----
// ----------------------------------------------------------------------------
// m3inv channel interfaces
// Valid/ready channels for the input matrix and the inverse result.
// ----------------------------------------------------------------------------
interface m3inv_mat_if;
	import m3inv_pkg::*;
	logic valid;
	logic ready;
	logic signed [DW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
	modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		input ready);
	modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		output ready);
endinterface

interface m3inv_inv_if;
	import m3inv_pkg::*;
	logic valid;
	logic ready;
	logic signed [DW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic singular;
	logic saturated;
	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		singular, saturated, input ready);
	modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		singular, saturated, output ready);
endinterface

// ----- sv/m3inv_div.sv -----
// ----------------------------------------------------------------------------
// m3inv_div
// Pipelined restoring divider for nine numerators over one shared
// denominator: one quotient bit per stage, then saturation and sign.
// ----------------------------------------------------------------------------
module m3inv_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	input  m3inv_pkg::div_in_t up_data,
	output logic               up_ready,
	output logic               dn_valid,
	output m3inv_pkg::inv_res_t dn_data,
	input  logic               dn_ready
);
	import m3inv_pkg::*;

	logic [DIV_NS-1:0] v_sd;
	logic [DIV_NS-1:0] en_sd;
	logic [NE-1:0][NUM_W-1:0] rem_sd [DIV_NS];
	logic [NE-1:0][DW-1:0]    q_sd   [DIV_NS];
	logic [NE-1:0]            ovf_sd [DIV_NS];
	logic [NE-1:0]            neg_sd [DIV_NS];
	logic                     sing_sd[DIV_NS];
	logic [DET_W-1:0]         den_sd [DIV_NS];

	logic     v_so;
	logic     en_so;
	inv_res_t res_so;
	inv_res_t res_d;

	// stage advances when empty or when the next one advances
	assign en_so    = !v_so || dn_ready;
	assign up_ready = en_sd[0];

	genvar i;
	generate
		for (i = 0; i < DIV_NS; i++) begin : g_st
			if (i == DIV_NS - 1) begin : g_last
				assign en_sd[i] = !v_sd[i] || en_so;
			end else begin : g_mid
				assign en_sd[i] = !v_sd[i] || en_sd[i+1];
			end

			if (i == 0) begin : g_ovf
				// flag quotients that reach 2^DW; no bit stage can hold them
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) v_sd[i] <= 1'b0;
					else if (en_sd[i]) v_sd[i] <= up_valid;
				end
				always_ff @(posedge clk) begin
					if (en_sd[i]) begin
						for (int k = 0; k < NE; k++) begin
							ovf_sd[i][k] <= CMP_W'(up_data.num[k]) >=
								(CMP_W'(up_data.den) << DW);
							rem_sd[i][k] <= up_data.num[k];
							q_sd[i][k]   <= '0;
						end
						neg_sd[i]  <= up_data.neg;
						sing_sd[i] <= up_data.sing;
						den_sd[i]  <= up_data.den;
					end
				end
			end else begin : g_bit
				localparam int B = DW - i;
				logic [NE-1:0][NUM_W-1:0] rem_d;
				logic [NE-1:0][DW-1:0]    q_d;

				// trial subtract of the shifted denominator
				always_comb begin
					logic [CMP_W-1:0] trial;
					trial = CMP_W'(den_sd[i-1]) << B;
					for (int k = 0; k < NE; k++) begin
						if (CMP_W'(rem_sd[i-1][k]) >= trial) begin
							rem_d[k] = rem_sd[i-1][k] - NUM_W'(trial);
							q_d[k]   = q_sd[i-1][k] | (DW'(1) << B);
						end else begin
							rem_d[k] = rem_sd[i-1][k];
							q_d[k]   = q_sd[i-1][k];
						end
					end
				end

				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) v_sd[i] <= 1'b0;
					else if (en_sd[i]) v_sd[i] <= v_sd[i-1];
				end
				always_ff @(posedge clk) begin
					if (en_sd[i]) begin
						rem_sd[i]  <= rem_d;
						q_sd[i]    <= q_d;
						ovf_sd[i]  <= ovf_sd[i-1];
						neg_sd[i]  <= neg_sd[i-1];
						sing_sd[i] <= sing_sd[i-1];
						den_sd[i]  <= den_sd[i-1];
					end
				end
			end
		end
	endgenerate

	// apply sign and clip to the signed range
	always_comb begin
		logic [DW-1:0] q;
		logic          ng;
		logic          s;
		logic          any;
		any = 1'b0;
		for (int k = 0; k < NE; k++) begin
			q  = q_sd[DIV_NS-1][k];
			ng = neg_sd[DIV_NS-1][k] && !((q == '0) && !ovf_sd[DIV_NS-1][k]);
			if (!ng) begin
				s = ovf_sd[DIV_NS-1][k] || q[DW-1];
				res_d.r[k] = s ? {1'b0, {(DW-1){1'b1}}} : q;
			end else begin
				s = ovf_sd[DIV_NS-1][k] || (q > (DW'(1) << (DW - 1)));
				res_d.r[k] = s ? (DW'(1) << (DW - 1)) : (DW'(0) - q);
			end
			any = any | s;
		end
		res_d.sing = sing_sd[DIV_NS-1];
		res_d.sat  = any;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_so <= 1'b0;
		else if (en_so) v_so <= v_sd[DIV_NS-1];
	end
	always_ff @(posedge clk) begin
		if (en_so) res_so <= res_d;
	end

	assign dn_valid = v_so;
	assign dn_data  = res_so;

endmodule

// ----- sv/matrix_3x3_inverse.sv -----
// Pipeline: 5 front stages and 34 divider stages lie between input beat and result beat.
// Throughput: one matrix per cycle while inv.ready is high; the quotient pipeline retires one bit a stage.
// Each stage moves on when empty or when the next one moves, so bubbles close up.
// Reset: arst_n clears all stage valid bits at once; data registers are not reset.
// ----------------------------------------------------------------------------
// matrix_3x3_inverse
// Signed fixed-point 3x3 inverse by adjugate over determinant, with singular
// and saturation flags.
// ----------------------------------------------------------------------------
module matrix_3x3_inverse (
	input logic        clk,
	input logic        arst_n,
	m3inv_mat_if.sink  mat,
	m3inv_inv_if.source inv
);
	import m3inv_pkg::*;

	logic signed [DW-1:0] a_in [NE];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic div_ready;

	logic signed [2*DW-1:0] pp_s1 [NE];
	logic signed [2*DW-1:0] pn_s1 [NE];
	logic signed [DW-1:0]   row_s1 [3];
	logic signed [CW-1:0]   adj_s2 [NE];
	logic signed [DW-1:0]   row_s2 [3];
	logic signed [DPW-1:0]  plo_s3 [3];
	logic signed [DPW-1:0]  phi_s3 [3];
	logic signed [CW-1:0]   adj_s3 [NE];
	logic signed [DET_W-1:0] det_s4;
	logic signed [CW-1:0]   adj_s4 [NE];
	div_in_t                d_s5;
	div_in_t                d_d;
	logic signed [DET_W-1:0] det_d;
	inv_res_t               res;

	assign a_in[0] = mat.a00;
	assign a_in[1] = mat.a01;
	assign a_in[2] = mat.a02;
	assign a_in[3] = mat.a10;
	assign a_in[4] = mat.a11;
	assign a_in[5] = mat.a12;
	assign a_in[6] = mat.a20;
	assign a_in[7] = mat.a21;
	assign a_in[8] = mat.a22;

	// stage enables: advance when empty or when downstream advances
	assign en_s5 = !v_s5 || div_ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign mat.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= mat.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: the eighteen 2x2 minor products
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int k = 0; k < NE; k++) begin
				pp_s1[k] <= a_in[PX[k]] * a_in[PY[k]];
				pn_s1[k] <= a_in[NX[k]] * a_in[NY[k]];
			end
			for (int j = 0; j < 3; j++) row_s1[j] <= a_in[j];
		end
	end

	// stage 2: adjugate entries
	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int k = 0; k < NE; k++) adj_s2[k] <= CW'(pp_s1[k]) - CW'(pn_s1[k]);
			row_s2 <= row_s1;
		end
	end

	// stage 3: determinant partial products, cofactor split into halves
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= row_s2[j] * $signed({1'b0, adj_s2[3*j][DW-1:0]});
				phi_s3[j] <= row_s2[j] * $signed(adj_s2[3*j][CW-1:DW]);
			end
			adj_s3 <= adj_s2;
		end
	end

	// stage 4: sum the partials into the determinant
	always_comb begin
		det_d = '0;
		for (int j = 0; j < 3; j++) begin
			det_d = det_d + DET_W'(plo_s3[j]) + (DET_W'(phi_s3[j]) <<< DW);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			det_s4 <= det_d;
			adj_s4 <= adj_s3;
		end
	end

	// stage 5: magnitudes, signs, and unit determinant for the singular case
	always_comb begin
		logic          dneg;
		logic [CW-1:0] mag;
		d_d.sing = (det_s4 == '0);
		dneg     = det_s4[DET_W-1];
		if (d_d.sing) d_d.den = DET_W'(1) << (3 * FB);
		else if (dneg) d_d.den = DET_W'(0) - DET_W'(det_s4);
		else d_d.den = DET_W'(det_s4);
		for (int k = 0; k < NE; k++) begin
			mag = adj_s4[k][CW-1] ? (CW'(0) - CW'(adj_s4[k])) : CW'(adj_s4[k]);
			d_d.num[k] = NUM_W'(mag) << (2 * FB);
			d_d.neg[k] = adj_s4[k][CW-1] ^ (!d_d.sing && dneg);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) d_s5 <= d_d;
	end

	m3inv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s5),
		.up_data  (d_s5),
		.up_ready (div_ready),
		.dn_valid (inv.valid),
		.dn_data  (res),
		.dn_ready (inv.ready)
	);

	assign inv.r00       = res.r[0];
	assign inv.r01       = res.r[1];
	assign inv.r02       = res.r[2];
	assign inv.r10       = res.r[3];
	assign inv.r11       = res.r[4];
	assign inv.r12       = res.r[5];
	assign inv.r20       = res.r[6];
	assign inv.r21       = res.r[7];
	assign inv.r22       = res.r[8];
	assign inv.singular  = res.sing;
	assign inv.saturated = res.sat;

endmodule

// ----- sv/m3inv_chk.sv -----
// ----------------------------------------------------------------------------
// m3inv_chk
// Port-level checks of the inverse pipeline: output hold under stall and
// in-flight beat accounting.
// ----------------------------------------------------------------------------
module m3inv_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [m3inv_pkg::DW-1:0]    r00,
	input logic                        singular,
	input logic                        saturated
);
	import m3inv_pkg::*;

	localparam int CNT_W = $clog2(LATENCY + 1) + 1;

	logic [CNT_W-1:0] cnt_q;
	logic in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// count beats inside the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped under stall");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(r00) && $stable(singular) && $stable(saturated))
		else $error("result payload changed under stall");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("result beat without an input beat");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LATENCY))
		else $error("more beats in flight than pipeline stages");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> in_ready)
		else $error("empty pipeline refuses input");

endmodule

bind matrix_3x3_inverse m3inv_chk u_m3inv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (mat.valid),
	.in_ready  (mat.ready),
	.out_valid (inv.valid),
	.out_ready (inv.ready),
	.r00       (inv.r00),
	.singular  (inv.singular),
	.saturated (inv.saturated)
);
